@@ rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared item types, control and status bundles, round constants and the
// SHA-256 mixing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

    // Input item: one message byte and its end-of-message flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } msg_item_t;

    // Output item: one digest word with its position.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    // Commands from the sequencer to the compression core.
    typedef struct packed {
        logic       byte_en;
        logic [7:0] byte_val;
        logic       start;
        logic       init_chain;
        logic [2:0] rd_idx;
    } core_ctrl_t;

    // Status from the compression core.
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] rd_word;
    } core_stat_t;

    localparam int unsigned ROUNDS     = 64;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;
    localparam logic [5:0]  BLOCK_END  = 6'd63;
    localparam logic [2:0]  LAST_WORD  = 3'd7;

    // Initial chaining value, word by word.
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] val;
        begin
            case (idx)
                3'd0:    val = 32'h6a09e667;
                3'd1:    val = 32'hbb67ae85;
                3'd2:    val = 32'h3c6ef372;
                3'd3:    val = 32'ha54ff53a;
                3'd4:    val = 32'h510e527f;
                3'd5:    val = 32'h9b05688c;
                3'd6:    val = 32'h1f83d9ab;
                default: val = 32'h5be0cd19;
            endcase
            return val;
        end
    endfunction

    // Round constants.
    function automatic logic [31:0] round_k(input logic [5:0] rnd);
        logic [31:0] val;
        begin
            case (rnd)
                6'd0:  val = 32'h428a2f98;  6'd1:  val = 32'h71374491;
                6'd2:  val = 32'hb5c0fbcf;  6'd3:  val = 32'he9b5dba5;
                6'd4:  val = 32'h3956c25b;  6'd5:  val = 32'h59f111f1;
                6'd6:  val = 32'h923f82a4;  6'd7:  val = 32'hab1c5ed5;
                6'd8:  val = 32'hd807aa98;  6'd9:  val = 32'h12835b01;
                6'd10: val = 32'h243185be;  6'd11: val = 32'h550c7dc3;
                6'd12: val = 32'h72be5d74;  6'd13: val = 32'h80deb1fe;
                6'd14: val = 32'h9bdc06a7;  6'd15: val = 32'hc19bf174;
                6'd16: val = 32'he49b69c1;  6'd17: val = 32'hefbe4786;
                6'd18: val = 32'h0fc19dc6;  6'd19: val = 32'h240ca1cc;
                6'd20: val = 32'h2de92c6f;  6'd21: val = 32'h4a7484aa;
                6'd22: val = 32'h5cb0a9dc;  6'd23: val = 32'h76f988da;
                6'd24: val = 32'h983e5152;  6'd25: val = 32'ha831c66d;
                6'd26: val = 32'hb00327c8;  6'd27: val = 32'hbf597fc7;
                6'd28: val = 32'hc6e00bf3;  6'd29: val = 32'hd5a79147;
                6'd30: val = 32'h06ca6351;  6'd31: val = 32'h14292967;
                6'd32: val = 32'h27b70a85;  6'd33: val = 32'h2e1b2138;
                6'd34: val = 32'h4d2c6dfc;  6'd35: val = 32'h53380d13;
                6'd36: val = 32'h650a7354;  6'd37: val = 32'h766a0abb;
                6'd38: val = 32'h81c2c92e;  6'd39: val = 32'h92722c85;
                6'd40: val = 32'ha2bfe8a1;  6'd41: val = 32'ha81a664b;
                6'd42: val = 32'hc24b8b70;  6'd43: val = 32'hc76c51a3;
                6'd44: val = 32'hd192e819;  6'd45: val = 32'hd6990624;
                6'd46: val = 32'hf40e3585;  6'd47: val = 32'h106aa070;
                6'd48: val = 32'h19a4c116;  6'd49: val = 32'h1e376c08;
                6'd50: val = 32'h2748774c;  6'd51: val = 32'h34b0bcb5;
                6'd52: val = 32'h391c0cb3;  6'd53: val = 32'h4ed8aa4a;
                6'd54: val = 32'h5b9cca4f;  6'd55: val = 32'h682e6ff3;
                6'd56: val = 32'h748f82ee;  6'd57: val = 32'h78a5636f;
                6'd58: val = 32'h84c87814;  6'd59: val = 32'h8cc70208;
                6'd60: val = 32'h90befffa;  6'd61: val = 32'ha4506ceb;
                6'd62: val = 32'hbef9a3f7;  6'd63: val = 32'hc67178f2;
                default: val = 32'hc67178f2;
            endcase
            return val;
        end
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/sha_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Holds the block window, the chaining value and the working variables, and
// runs one compression round per cycle through a single shared round unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire core_ctrl_t ctrl,
    output core_stat_t      stat
);

    localparam logic [1:0] C_IDLE   = 2'd0;
    localparam logic [1:0] C_ROUND  = 2'd1;
    localparam logic [1:0] C_UPDATE = 2'd2;

    logic [1:0]   cst_reg, cst_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [511:0] win_reg, win_next;
    logic [31:0]  chain_reg [8];
    logic [31:0]  chain_next [8];
    logic [31:0]  work_reg [8];
    logic [31:0]  work_next [8];

    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // Message schedule: the window holds sixteen words, oldest at the top.
    assign w_cur = win_reg[511:480];
    assign w_new = win_reg[511:480] + small_sigma0(win_reg[479:448])
                 + win_reg[223:192] + small_sigma1(win_reg[63:32]);

    // Shared round unit.
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + round_k(rnd_reg) + w_cur;
    assign t2  = big_sigma0(work_reg[0]) + maj;

    // Sequencing of rounds and the final chaining update.
    always_comb
    begin
        cst_next   = cst_reg;
        rnd_next   = rnd_reg;
        win_next   = win_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        case (cst_reg)
            C_IDLE:
            begin
                if (ctrl.byte_en)
                begin
                    win_next = {win_reg[503:0], ctrl.byte_val};
                end
                if (ctrl.start)
                begin
                    work_next = chain_reg;
                    rnd_next  = 6'd0;
                    cst_next  = C_ROUND;
                end
                if (ctrl.init_chain)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_next[i] = init_hash(3'(i));
                    end
                end
            end
            C_ROUND:
            begin
                win_next     = {win_reg[479:0], w_new};
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == 6'(ROUNDS - 1))
                begin
                    cst_next = C_UPDATE;
                end
            end
            C_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                cst_next = C_IDLE;
            end
            default:
            begin
                cst_next = C_IDLE;
            end
        endcase
    end

    // Control state and chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cst_reg <= C_IDLE;
            rnd_reg <= 6'd0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            cst_reg   <= cst_next;
            rnd_reg   <= rnd_next;
            chain_reg <= chain_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    assign stat.busy    = (cst_reg != C_IDLE);
    assign stat.done    = (cst_reg == C_UPDATE);
    assign stat.rd_word = chain_reg[ctrl.rd_idx];

endmodule

`default_nettype wire

@@ rtl/sha256_message_hasher.sv @@
// Input: a message byte that neither closes a block nor ends the message leaves the input ready for the next byte.
// A byte that closes a block holds the input off while the core runs the 64
// rounds of the shared round unit and one chaining update, then the hasher returns to idle.
// The final byte is followed by up to 72 padding bytes and one or two
// compressions, then eight digest items at one per cycle as they are taken.
// Reset: chaining value to the SHA-256 initial hash, byte count to zero.
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Takes a message a byte at a time, pads the final block, and returns the
// digest as eight 32-bit big-endian words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher
    import sha_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         msg_valid,
    output logic              msg_ready,
    input  wire msg_item_t    msg_item,
    output logic              digest_valid,
    input  wire logic         digest_ready,
    output digest_item_t      digest_item
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PAD  = 2'd1;
    localparam logic [1:0] S_HASH = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] count_reg, count_next;
    logic        pad_reg, pad_next;
    logic        first_reg, first_next;
    logic        len_ok_reg, len_ok_next;
    logic [2:0]  idx_reg, idx_next;

    core_ctrl_t  ctrl;
    core_stat_t  stat;

    logic        msg_fire;
    logic        digest_fire;
    logic [63:0] len_shift;
    logic [7:0]  pad_byte;

    assign msg_fire    = msg_valid && msg_ready;
    assign digest_fire = digest_valid && digest_ready;

    // Padding byte: marker, then zeros, then the bit length from the top byte down.
    assign len_shift = {count_reg[60:0], 3'b000} << {pos_reg[2:0], 3'b000};
    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (len_ok_reg && (pos_reg >= LEN_OFFSET))
        begin
            pad_byte = len_shift[63:56];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Block sequencer.
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        pad_next    = pad_reg;
        first_next  = first_reg;
        len_ok_next = len_ok_reg;
        idx_next    = idx_reg;
        ctrl        = '0;
        ctrl.rd_idx = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (msg_fire)
                begin
                    ctrl.byte_en  = 1'b1;
                    ctrl.byte_val = msg_item.data_byte;
                    pos_next      = pos_reg + 6'd1;
                    count_next    = count_reg + 64'd1;
                    if (msg_item.last_byte)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                    end
                    if (pos_reg == BLOCK_END)
                    begin
                        ctrl.start = 1'b1;
                        state_next = S_HASH;
                    end
                    else if (msg_item.last_byte)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                ctrl.byte_en  = 1'b1;
                ctrl.byte_val = pad_byte;
                pos_next      = pos_reg + 6'd1;
                first_next    = 1'b0;
                len_ok_next   = len_ok_reg || (pos_reg < LEN_OFFSET);
                if (pos_reg == BLOCK_END)
                begin
                    ctrl.start = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (stat.done)
                begin
                    if (pad_reg && len_ok_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else if (pad_reg)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                if (digest_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_WORD)
                    begin
                        ctrl.init_chain = 1'b1;
                        count_next      = 64'd0;
                        pad_next        = 1'b0;
                        len_ok_next     = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= 6'd0;
            count_reg  <= 64'd0;
            pad_reg    <= 1'b0;
            first_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
            idx_reg    <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            pad_reg    <= pad_next;
            first_reg  <= first_next;
            len_ok_reg <= len_ok_next;
            idx_reg    <= idx_next;
        end
    end

    sha_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    // Handshakes and the digest item, taken from the stable chaining value.
    assign msg_ready               = (state_reg == S_IDLE);
    assign digest_valid            = (state_reg == S_OUT);
    assign digest_item.digest_word = stat.rd_word;
    assign digest_item.word_index  = idx_reg;
    assign digest_item.last_word   = (idx_reg == LAST_WORD);

    // The input is never taken while a compression is running.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        msg_ready |-> !stat.busy)
        else $error("input ready during compression");

    // Padding always ends on a block boundary.
    a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (pos_reg == 6'd0) && !first_reg)
        else $error("digest offered off a block boundary");

    // Digest words leave in order.
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        digest_fire && !digest_item.last_word |=> digest_valid
            && (idx_reg == $past(idx_reg) + 3'd1))
        else $error("digest word out of order");

    // After the final word the hasher is idle with a cleared count.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        digest_fire && digest_item.last_word |=> msg_ready && (count_reg == 64'd0)
            && (idx_reg == 3'd0))
        else $error("hasher did not re-initialise");

endmodule

`default_nettype wire

@@ tb/sha256_digest_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both item channels of the message hasher. It keeps its own copy of
// the chaining value, block buffer and byte count, and computes the expected
// digest words for every message. It then compares each digest item that is
// taken with the oldest expected word.
// ----------------------------------------------------------------------------
module sha256_digest_checker
    import sha_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    input  logic         msg_ready,
    input  msg_item_t    msg_item,
    input  logic         digest_valid,
    input  logic         digest_ready,
    input  digest_item_t digest_item,
    output int           fail_count,
    output int           words_pending,
    output int           digests_done
);

    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LENGTH_OFFSET = 6'd56;
    localparam logic [5:0] FINAL_SLOT    = 6'd63;

    // Predicted hasher state.
    logic [31:0]  chain_word [0:7];
    logic [7:0]   block_buf  [0:63];
    logic [63:0]  byte_total;

    digest_item_t expected_words [$];
    digest_item_t want;
    int           errors;
    int           messages;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One full compression of the block buffer into the chaining value.
    function automatic void mix_block();
        logic [31:0] w [0:63];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            s0   = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1   = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain_word[0]; b = chain_word[1]; c = chain_word[2]; d = chain_word[3];
        e = chain_word[4]; f = chain_word[5]; g = chain_word[6]; h = chain_word[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_CONST[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_word[0] += a; chain_word[1] += b; chain_word[2] += c; chain_word[3] += d;
        chain_word[4] += e; chain_word[5] += f; chain_word[6] += g; chain_word[7] += h;
    endfunction

    // Append one byte to the block, compressing when the block fills.
    function automatic void absorb_byte(input logic [7:0] val);
        logic [5:0] slot;
        slot            = byte_total[5:0];
        block_buf[slot] = val;
        byte_total      = byte_total + 64'd1;
        if (slot == FINAL_SLOT)
        begin
            mix_block();
        end
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
        begin
            chain_word[i] = IV_WORDS[i];
        end
        byte_total = '0;
    endfunction

    // Take one accepted message byte; on the final byte, pad the message and
    // queue the eight digest words.
    function automatic void hash_accepted_byte(input msg_item_t item);
        logic [63:0]  bit_len;
        digest_item_t word;
        absorb_byte(item.data_byte);
        if (item.last_byte)
        begin
            bit_len = byte_total << 3;
            absorb_byte(PAD_BYTE);
            while (byte_total[5:0] != LENGTH_OFFSET)
            begin
                absorb_byte(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                absorb_byte(bit_len[63 - 8*i -: 8]);
            end
            for (int i = 0; i < 8; i++)
            begin
                word.digest_word = chain_word[i];
                word.word_index  = 3'(i);
                word.last_word   = (i == 7);
                expected_words.push_back(word);
            end
            restart_message();
            messages++;
        end
    endfunction

    // Compare digest items first, then take the message byte: a byte taken in
    // this cycle cannot have produced an item in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            expected_words.delete();
            errors        = 0;
            messages      = 0;
            fail_count    <= 0;
            words_pending <= 0;
            digests_done  <= 0;
        end
        else
        begin
            if (digest_valid && digest_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected digest item: word %08h index %0d last %0b",
                             $time, digest_item.digest_word, digest_item.word_index,
                             digest_item.last_word);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (digest_item.digest_word !== want.digest_word)
                    begin
                        $display("%0t: digest_word mismatch at index %0d: expected %08h, got %08h",
                                 $time, want.word_index, want.digest_word,
                                 digest_item.digest_word);
                        errors++;
                    end
                    if (digest_item.word_index !== want.word_index)
                    begin
                        $display("%0t: word_index mismatch: expected %0d, got %0d",
                                 $time, want.word_index, digest_item.word_index);
                        errors++;
                    end
                    if (digest_item.last_word !== want.last_word)
                    begin
                        $display("%0t: last_word mismatch at index %0d: expected %0b, got %0b",
                                 $time, want.word_index, want.last_word,
                                 digest_item.last_word);
                        errors++;
                    end
                end
            end
            if (msg_valid && msg_ready)
            begin
                hash_accepted_byte(msg_item);
            end
            fail_count    <= errors;
            words_pending <= expected_words.size();
            digests_done  <= messages;
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Feeds messages of assorted lengths to the hasher a byte at a time, with
// random gaps on both channels. The checker beside the block predicts and
// compares the digests, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import sha_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_LEN   = 200;
    localparam int BYTE_TARGET  = 270;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         msg_valid    = 1'b0;
    logic         msg_ready;
    msg_item_t    msg_item     = '0;
    logic         digest_valid;
    logic         digest_ready = 1'b0;
    digest_item_t digest_item;

    // Set while neither side may idle.
    logic         steady       = 1'b0;

    int           fail_count;
    int           words_pending;
    int           digests_done;
    int           bytes_sent   = 0;
    int           quiet_cycles = 0;
    logic [7:0]   msg_bytes [$];

    sha256_message_hasher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg_item     (msg_item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_item  (digest_item)
    );

    sha256_digest_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg_valid     (msg_valid),
        .msg_ready     (msg_ready),
        .msg_item      (msg_item),
        .digest_valid  (digest_valid),
        .digest_ready  (digest_ready),
        .digest_item   (digest_item),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .digests_done  (digests_done)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Digest receiver stalls in about a quarter of cycles.
    always @(posedge clk)
    begin
        digest_ready <= steady || ($urandom_range(99) >= 23);
    end

    // Watchdog on cycles in which no item moves on either channel.
    always @(posedge clk)
    begin
        if ((msg_valid && msg_ready) || (digest_valid && digest_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send the bytes in msg_bytes as one message, last flag on the final byte.
    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
        begin
            while (!steady && $urandom_range(99) < 23)
            begin
                msg_valid <= 1'b0;
                @(posedge clk);
            end
            msg_valid <= 1'b1;
            msg_item  <= '{data_byte: msg_bytes[i], last_byte: (i == msg_bytes.size() - 1)};
            do
            begin
                @(posedge clk);
            end
            while (!msg_ready);
            bytes_sent++;
        end
    endtask

    task automatic send_random_message(input int len);
        msg_bytes.delete();
        for (int i = 0; i < len; i++)
        begin
            msg_bytes.push_back(8'($urandom_range(255)));
        end
        send_message();
    endtask

    // Hold the sender off until every expected digest word has come back.
    task automatic drain_digests();
        msg_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte messages at both byte extremes, the pad value
        // itself as data, and the classic three-byte message back to back.
        msg_bytes = '{8'h00};
        send_message();
        msg_bytes = '{8'hff};
        send_message();
        msg_bytes = '{8'h80};
        send_message();
        msg_bytes = '{8'h61, 8'h62, 8'h63};
        send_message();
        drain_digests();
        msg_bytes = '{8'h61, 8'h62, 8'h63};
        send_message();
        msg_bytes = '{8'h55, 8'haa, 8'h0f, 8'hf0};
        send_message();
        drain_digests();

        // Padding boundaries: the longest message that fits one block, the
        // shortest that spills into a second, and an exactly full block
        // sent and drained with no idling on either side.
        send_random_message(55);
        send_random_message(56);
        steady <= 1'b1;
        send_random_message(64);
        drain_digests();
        steady <= 1'b0;

        // Short random messages, sometimes draining in between.
        while (bytes_sent < BYTE_TARGET)
        begin
            send_random_message($urandom_range(20, 1));
            if ($urandom_range(3) == 0)
            begin
                drain_digests();
            end
        end

        drain_digests();
        repeat (SETTLE_LEN) @(posedge clk);

        $display("Sent %0d message bytes in %0d messages, lengths 1 to 64 bytes",
                 bytes_sent, digests_done);
        $display("including one- and two-block padding and idling on both channels.");
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
